/* rtl/core/tpl_pkg.sv */
// ----------------------------------------------------------------------------
// tpl_pkg
// widths, latencies and types shared by the tetrahedron local coordinate core
// ----------------------------------------------------------------------------
package tpl_pkg;

   localparam int COORD_WIDTH = 32;
   localparam int FRAC_BITS   = 16;

   // difference of two coordinates
   localparam int DIFF_W  = COORD_WIDTH + 1;
   // product of two differences and a 2x2 cofactor
   localparam int PROD_W  = 2 * DIFF_W;
   localparam int COF_W   = PROD_W + 1;
   // cofactor split for the top-row multiply
   localparam int LO_W    = DIFF_W + 1;
   localparam int HI_W    = COF_W - LO_W;
   // full 3x3 determinant
   localparam int DET_W   = 3 * DIFF_W + 3;
   // shifted numerator and working remainder of the divider
   localparam int NUM_W   = DET_W + FRAC_BITS;
   localparam int REM_W   = NUM_W + COORD_WIDTH;

   localparam int DET_LAT  = 4;
   localparam int DIV_LAT  = COORD_WIDTH + 2;
   localparam int PIPE_LAT = 1 + DET_LAT + DIV_LAT;

   localparam logic REQ_LOAD  = 1'b0;
   localparam logic REQ_QUERY = 1'b1;

   typedef logic signed [COORD_WIDTH-1:0] coord_type;
   typedef logic signed [DIFF_W-1:0]      diff_type;
   typedef logic signed [DET_W-1:0]       det_type;
   typedef diff_type                      mat_type [3][3];

endpackage

/* rtl/core/tpl_req_if.sv */
// ----------------------------------------------------------------------------
// tpl_req_if
// request channel: vertex loads and point queries
// ----------------------------------------------------------------------------
interface tpl_req_if;
   import tpl_pkg::*;

   logic       valid;
   logic       ready;
   logic       req_type;
   logic [1:0] vertex_slot;
   coord_type  x_coord;
   coord_type  y_coord;
   coord_type  z_coord;

   modport source (output valid, req_type, vertex_slot, x_coord, y_coord, z_coord,
                   input ready);
   modport sink   (input valid, req_type, vertex_slot, x_coord, y_coord, z_coord,
                   output ready);
endinterface

/* rtl/core/tpl_rsp_if.sv */
// ----------------------------------------------------------------------------
// tpl_rsp_if
// response channel: local coordinates of a queried point
// ----------------------------------------------------------------------------
interface tpl_rsp_if;
   import tpl_pkg::*;

   logic      valid;
   logic      ready;
   coord_type xi;
   coord_type eta;
   coord_type zeta;
   logic      degenerate;
   logic      clipped;

   modport source (output valid, xi, eta, zeta, degenerate, clipped, input ready);
   modport sink   (input valid, xi, eta, zeta, degenerate, clipped, output ready);
endinterface

/* rtl/core/tet_point_local_coords.sv */
// ----------------------------------------------------------------------------
// tet_point_local_coords
// local coordinates of a point in a tetrahedron by Cramer's rule
// ----------------------------------------------------------------------------
//  channel   dir  handshake      payload
//  req_chan  in   valid/ready    req_type, vertex_slot, x/y/z_coord
//  rsp_chan  out  valid/ready    xi, eta, zeta, degenerate, clipped
//
//  one request per cycle while the response is not stalled; a query passes
//  one edge stage, four determinant stages, and in the divider an input stage,
//  one stage per quotient bit and an output stage.
//  loads write the vertex registers at acceptance and give no response.
//  synchronous reset clears the valid bits only; vertices are unknown until loaded.
//  a stalled response freezes the whole pipeline, nothing is dropped or repeated.
// ----------------------------------------------------------------------------
module tet_point_local_coords import tpl_pkg::*; (
   input  logic  clock,
   input  logic  reset,
   tpl_req_if.sink   req_chan,
   tpl_rsp_if.source rsp_chan
);

   coord_type vtx_ff [4][3];
   diff_type  e_ff [3][3];
   diff_type  p_ff [3];
   logic [PIPE_LAT-1:0] vld_ff, vld_in;
   coord_type pt [3];
   mat_type   mat [4];
   det_type   det [4];
   logic      en, accept, zero_det;
   logic      clip_q [3];
   logic      kill_q [3];

   assign en              = !rsp_chan.valid || rsp_chan.ready;
   assign req_chan.ready  = en;
   assign accept          = req_chan.valid && en;
   assign pt[0] = req_chan.x_coord;
   assign pt[1] = req_chan.y_coord;
   assign pt[2] = req_chan.z_coord;

   always_ff @(posedge clock) begin
      if (accept && req_chan.req_type == REQ_LOAD) begin
         for (int a = 0; a < 3; a++) vtx_ff[req_chan.vertex_slot][a] <= pt[a];
      end
      if (en) begin
         // e[axis][edge], p = point minus first vertex
         for (int a = 0; a < 3; a++) begin
            p_ff[a] <= DIFF_W'(pt[a]) - DIFF_W'(vtx_ff[0][a]);
            for (int k = 0; k < 3; k++)
               e_ff[a][k] <= DIFF_W'(vtx_ff[k+1][a]) - DIFF_W'(vtx_ff[0][a]);
         end
      end
   end

   always_comb begin
      for (int m = 0; m < 4; m++)
         for (int a = 0; a < 3; a++)
            for (int k = 0; k < 3; k++)
               mat[m][a][k] = (m == k + 1) ? p_ff[a] : e_ff[a][k];
      vld_in = {vld_ff[PIPE_LAT-2:0], accept && req_chan.req_type == REQ_QUERY};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= vld_in;
      end
   end

   for (genvar g = 0; g < 4; g++) begin : g_det
      tpl_det u_det (.clock(clock), .en(en), .mat(mat[g]), .det(det[g]));
   end

   assign zero_det = (det[0] == '0);

   tpl_div u_div_xi (.clock(clock), .en(en), .num(det[1]), .den(det[0]),
                     .kill(zero_det), .quo(rsp_chan.xi), .clip(clip_q[0]),
                     .kill_out(kill_q[0]));
   tpl_div u_div_eta (.clock(clock), .en(en), .num(det[2]), .den(det[0]),
                      .kill(zero_det), .quo(rsp_chan.eta), .clip(clip_q[1]),
                      .kill_out(kill_q[1]));
   tpl_div u_div_zeta (.clock(clock), .en(en), .num(det[3]), .den(det[0]),
                       .kill(zero_det), .quo(rsp_chan.zeta), .clip(clip_q[2]),
                       .kill_out(kill_q[2]));

   assign rsp_chan.valid      = vld_ff[PIPE_LAT-1];
   assign rsp_chan.degenerate = kill_q[0] && kill_q[1] && kill_q[2];
   assign rsp_chan.clipped    = clip_q[0] || clip_q[1] || clip_q[2];

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && !rsp_chan.ready |=> rsp_chan.valid && $stable(rsp_chan.xi))
      else $error("response changed while stalled");
   a_degen_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && rsp_chan.degenerate |->
         !rsp_chan.clipped && rsp_chan.xi == '0 && rsp_chan.eta == '0 && rsp_chan.zeta == '0)
      else $error("degenerate response not zero");
   a_load_silent: assert property (@(posedge clock) disable iff (reset)
      accept && req_chan.req_type == REQ_LOAD |=> !vld_ff[0])
      else $error("load entered the pipeline");
   a_no_accept_stalled: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && !rsp_chan.ready |-> !req_chan.ready)
      else $error("request taken during stall");

endmodule

/* rtl/core/tpl_det.sv */
// ----------------------------------------------------------------------------
// tpl_det
// four-stage 3x3 determinant: products, cofactors, split top-row multiply, sum
// ----------------------------------------------------------------------------
module tpl_det import tpl_pkg::*; (
   input  logic    clock,
   input  logic    en,
   input  mat_type mat,
   output det_type det
);

   logic signed [PROD_W-1:0]       pa_ff [3], pb_ff [3], pa_in [3], pb_in [3];
   logic signed [COF_W-1:0]        cof_ff [3], cof_in [3];
   logic signed [DIFF_W+LO_W:0]    lo_ff [3], lo_in [3];
   logic signed [DIFF_W+HI_W-1:0]  hi_ff [3], hi_in [3];
   diff_type                       r1_ff [3], r2_ff [3];
   det_type                        det_ff, det_in;
   det_type                        term [3];

   always_comb begin
      for (int c = 0; c < 3; c++) begin
         int a, b;
         a = (c == 0) ? 1 : 0;
         b = (c == 2) ? 1 : 2;
         pa_in[c] = mat[1][a] * mat[2][b];
         pb_in[c] = mat[1][b] * mat[2][a];
         cof_in[c] = COF_W'(pa_ff[c]) - COF_W'(pb_ff[c]);
         lo_in[c] = r2_ff[c] * $signed({1'b0, cof_ff[c][LO_W-1:0]});
         hi_in[c] = r2_ff[c] * $signed(cof_ff[c][COF_W-1:LO_W]);
         term[c] = (DET_W'(hi_ff[c]) <<< LO_W) + DET_W'(lo_ff[c]);
      end
      det_in = term[0] - term[1] + term[2];
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int c = 0; c < 3; c++) begin
            pa_ff[c]  <= pa_in[c];
            pb_ff[c]  <= pb_in[c];
            r1_ff[c]  <= mat[0][c];
            cof_ff[c] <= cof_in[c];
            r2_ff[c]  <= r1_ff[c];
            lo_ff[c]  <= lo_in[c];
            hi_ff[c]  <= hi_in[c];
         end
         det_ff <= det_in;
      end
   end

   assign det = det_ff;

endmodule

/* rtl/core/tpl_div.sv */
// ----------------------------------------------------------------------------
// tpl_div
// pipelined restoring divider, one quotient bit per stage, Q-format saturation
// ----------------------------------------------------------------------------
module tpl_div import tpl_pkg::*; (
   input  logic      clock,
   input  logic      en,
   input  det_type   num,
   input  det_type   den,
   input  logic      kill,
   output coord_type quo,
   output logic      clip,
   output logic      kill_out
);

   logic [REM_W-1:0]       rem_ff [COORD_WIDTH+1], rem_in [COORD_WIDTH+1];
   logic [DET_W-1:0]       md_ff  [COORD_WIDTH+1];
   logic [COORD_WIDTH-1:0] q_ff   [COORD_WIDTH+1], q_in [COORD_WIDTH+1];
   logic                   neg_ff [COORD_WIDTH+1];
   logic                   big_ff [COORD_WIDTH+1];
   logic                   kill_ff [COORD_WIDTH+1];

   logic [DET_W-1:0]       abs_num, abs_den;
   logic [REM_W-1:0]       mn;
   logic                   big;
   logic [COORD_WIDTH-1:0] lim, mag, res;
   logic                   sat;
   coord_type              quo_ff;
   logic                   clip_ff, kill_out_ff;

   always_comb begin
      abs_num = num[DET_W-1] ? DET_W'(-num) : DET_W'(num);
      abs_den = den[DET_W-1] ? DET_W'(-den) : DET_W'(den);
      mn      = REM_W'(abs_num) << FRAC_BITS;
      big     = mn >= (REM_W'(abs_den) << COORD_WIDTH);
      rem_in[0] = mn;
      q_in[0]   = '0;
      for (int i = 0; i < COORD_WIDTH; i++) begin
         logic [REM_W:0] trial;
         trial = {1'b0, rem_ff[i]} - {1'b0, REM_W'(md_ff[i]) << (COORD_WIDTH - 1 - i)};
         rem_in[i+1] = trial[REM_W] ? rem_ff[i] : trial[REM_W-1:0];
         q_in[i+1]   = q_ff[i] |
                       (COORD_WIDTH'(!trial[REM_W]) << (COORD_WIDTH - 1 - i));
      end
      lim = neg_ff[COORD_WIDTH] ? (COORD_WIDTH'(1) << (COORD_WIDTH - 1))
                                : ((COORD_WIDTH'(1) << (COORD_WIDTH - 1)) - 1'b1);
      sat = big_ff[COORD_WIDTH] || (q_ff[COORD_WIDTH] > lim);
      mag = sat ? lim : q_ff[COORD_WIDTH];
      res = neg_ff[COORD_WIDTH] ? (~mag + 1'b1) : mag;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff[0]  <= rem_in[0];
         md_ff[0]   <= abs_den;
         q_ff[0]    <= q_in[0];
         neg_ff[0]  <= num[DET_W-1] ^ den[DET_W-1];
         big_ff[0]  <= big;
         kill_ff[0] <= kill;
         for (int i = 0; i < COORD_WIDTH; i++) begin
            rem_ff[i+1]  <= rem_in[i+1];
            md_ff[i+1]   <= md_ff[i];
            q_ff[i+1]    <= q_in[i+1];
            neg_ff[i+1]  <= neg_ff[i];
            big_ff[i+1]  <= big_ff[i];
            kill_ff[i+1] <= kill_ff[i];
         end
         // zero divisor forces a clean zero result
         quo_ff      <= kill_ff[COORD_WIDTH] ? '0 : $signed(res);
         clip_ff     <= !kill_ff[COORD_WIDTH] && sat;
         kill_out_ff <= kill_ff[COORD_WIDTH];
      end
   end

   assign quo      = quo_ff;
   assign clip     = clip_ff;
   assign kill_out = kill_out_ff;

endmodule

/* dv/tet_point_local_coords_tb.sv */
// ----------------------------------------------------------------------------
// tet_point_local_coords_tb
// self-checking bench: vertex loads and point queries with random handshake
// gaps; responses compared with typed-in values or an exact integer predictor
// ----------------------------------------------------------------------------
module tet_point_local_coords_tb import tpl_pkg::*; ();

   typedef struct packed {
      logic      rtype;
      logic [1:0] slot;
      coord_type x;
      coord_type y;
      coord_type z;
   } request_type;

   typedef struct packed {
      coord_type xi;
      coord_type eta;
      coord_type zeta;
      logic      degenerate;
      logic      clipped;
   } coords_type;

   typedef struct {
      request_type req;
      logic        known;   // expected response typed in
      coords_type  coords;
   } stim_row_type;

   localparam int ONE = 1 << FRAC_BITS;
   localparam logic signed [31:0] MAXC = 32'sh7fffffff;
   localparam logic signed [31:0] MINC = 32'sh80000000;

   logic clock;
   logic reset;
   tpl_req_if req_chan ();
   tpl_rsp_if rsp_chan ();

   tet_point_local_coords dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan.sink),
      .rsp_chan (rsp_chan.source)
   );

   coord_type  tet_vertex [4][3];
   logic [3:0] slot_loaded;
   coords_type coords_pending [$];
   int         errors;
   logic       no_gaps;

   function automatic logic signed [255:0] det3(input logic signed [255:0] m [3][3]);
      det3 = m[0][0] * (m[1][1] * m[2][2] - m[1][2] * m[2][1])
           - m[0][1] * (m[1][0] * m[2][2] - m[1][2] * m[2][0])
           + m[0][2] * (m[1][0] * m[2][1] - m[1][1] * m[2][0]);
   endfunction

   function automatic coord_type fixed_quot(input logic signed [255:0] num,
                                            input logic signed [255:0] den,
                                            inout logic clip);
      logic signed [255:0] q;
      q = (num <<< FRAC_BITS) / den;   // truncates toward zero
      if (q > MAXC) begin
         clip = 1'b1;
         return MAXC;
      end
      if (q < MINC) begin
         clip = 1'b1;
         return MINC;
      end
      return q[31:0];
   endfunction

   function automatic coords_type local_coords(input request_type r);
      logic signed [255:0] e [3][3];
      logic signed [255:0] m [3][3];
      logic signed [255:0] p [3];
      logic signed [255:0] d;
      coord_type qk [3];
      coords_type c;
      logic clip;
      clip = 1'b0;
      p[0] = r.x; p[1] = r.y; p[2] = r.z;
      for (int a = 0; a < 3; a++) begin
         p[a] = p[a] - tet_vertex[0][a];
         for (int k = 0; k < 3; k++)
            e[a][k] = 256'(signed'(tet_vertex[k+1][a])) - tet_vertex[0][a];
      end
      d = det3(e);
      c = '0;
      if (d == 0) begin
         c.degenerate = 1'b1;
         return c;
      end
      for (int k = 0; k < 3; k++) begin
         m = e;
         for (int a = 0; a < 3; a++) m[a][k] = p[a];
         qk[k] = fixed_quot(det3(m), d, clip);
      end
      c.xi = qk[0]; c.eta = qk[1]; c.zeta = qk[2];
      c.clipped = clip;
      return c;
   endfunction

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #50000000;
      $display("Verification failed");
      $finish;
   end

   // response side: random stalls, in-order compare
   initial begin
      int stall;
      coords_type want;
      rsp_chan.ready = 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         stall = (!no_gaps && $urandom_range(0, 5) == 0) ? $urandom_range(1, 18) : 0;
         if (stall > 0) begin
            rsp_chan.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_chan.ready <= 1'b1;
         @(posedge clock);
         if (rsp_chan.valid && rsp_chan.ready) begin
            if (coords_pending.size() == 0) begin
               $error("response with none expected");
               errors++;
            end else begin
               want = coords_pending.pop_front();
               if (rsp_chan.xi !== want.xi) begin
                  $error("xi expected %h actual %h", want.xi, rsp_chan.xi); errors++;
               end
               if (rsp_chan.eta !== want.eta) begin
                  $error("eta expected %h actual %h", want.eta, rsp_chan.eta); errors++;
               end
               if (rsp_chan.zeta !== want.zeta) begin
                  $error("zeta expected %h actual %h", want.zeta, rsp_chan.zeta); errors++;
               end
               if (rsp_chan.degenerate !== want.degenerate) begin
                  $error("degenerate expected %b actual %b", want.degenerate,
                         rsp_chan.degenerate); errors++;
               end
               if (rsp_chan.clipped !== want.clipped) begin
                  $error("clipped expected %b actual %b", want.clipped,
                         rsp_chan.clipped); errors++;
               end
            end
         end
      end
   end

   task automatic send_request(input request_type r, input logic known,
                               input coords_type c);
      int gap;
      gap = (!no_gaps && $urandom_range(0, 4) == 0) ? $urandom_range(1, 18) : 0;
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_chan.valid       <= 1'b1;
      req_chan.req_type    <= r.rtype;
      req_chan.vertex_slot <= r.slot;
      req_chan.x_coord     <= r.x;
      req_chan.y_coord     <= r.y;
      req_chan.z_coord     <= r.z;
      do @(posedge clock); while (!req_chan.ready);
      if (r.rtype == REQ_LOAD) begin
         tet_vertex[r.slot][0] = r.x;
         tet_vertex[r.slot][1] = r.y;
         tet_vertex[r.slot][2] = r.z;
         slot_loaded[r.slot] = 1'b1;
      end else begin
         if (slot_loaded != 4'hf) begin
            $error("query before all vertices loaded"); errors++;
         end
         coords_pending.push_back(known ? c : local_coords(r));
      end
   endtask

   function automatic request_type load_req(input int s, input coord_type x, y, z);
      load_req = '{REQ_LOAD, 2'(s), x, y, z};
   endfunction

   function automatic request_type query_req(input coord_type x, y, z);
      query_req = '{REQ_QUERY, 2'($urandom), x, y, z};
   endfunction

   function automatic coord_type rand_coord();
      case ($urandom_range(0, 5))
         0: return $urandom;
         1: return $urandom_range(0, 1) ? MAXC : MINC;
         default: return coord_type'(int'($urandom_range(0, 8 * ONE)) - 4 * ONE);
      endcase
   endfunction

   task automatic drain();
      req_chan.valid <= 1'b0;
      while (coords_pending.size() != 0) @(posedge clock);
      repeat (PIPE_LAT + 5) @(posedge clock);
   endtask

   initial begin
      stim_row_type table_rows [$];
      request_type r;
      coords_type none;
      int n;
      errors = 0;
      no_gaps = 1'b0;
      slot_loaded = '0;
      none = '0;
      reset = 1'b1;
      req_chan.valid = 1'b0;
      req_chan.req_type = REQ_LOAD;
      req_chan.vertex_slot = '0;
      req_chan.x_coord = '0;
      req_chan.y_coord = '0;
      req_chan.z_coord = '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // unit tetrahedron, corners, centroid and one outside point
      table_rows.push_back('{load_req(0, 0, 0, 0), 0, none});
      table_rows.push_back('{load_req(1, ONE, 0, 0), 0, none});
      table_rows.push_back('{load_req(2, 0, ONE, 0), 0, none});
      table_rows.push_back('{load_req(3, 0, 0, ONE), 0, none});
      table_rows.push_back('{query_req(0, 0, 0), 1, '{0, 0, 0, 0, 0}});
      table_rows.push_back('{query_req(ONE, 0, 0), 1, '{ONE, 0, 0, 0, 0}});
      table_rows.push_back('{query_req(0, ONE, 0), 1, '{0, ONE, 0, 0, 0}});
      table_rows.push_back('{query_req(0, 0, ONE), 1, '{0, 0, ONE, 0, 0}});
      table_rows.push_back('{query_req(ONE/4, ONE/4, ONE/4), 0, none});
      table_rows.push_back('{query_req(ONE/3, -ONE/3, 7), 0, none});
      // extremes of the point land exactly on the range limits
      table_rows.push_back('{query_req(MAXC, MAXC, MAXC), 1, '{MAXC, MAXC, MAXC, 0, 0}});
      table_rows.push_back('{query_req(MINC, MINC, MINC), 1, '{MINC, MINC, MINC, 0, 0}});
      table_rows.push_back('{query_req(MAXC, MINC, 0), 0, none});
      // flat tetrahedron
      table_rows.push_back('{load_req(3, ONE, ONE, 0), 0, none});
      table_rows.push_back('{query_req(5, 6, 7), 1, '{0, 0, 0, 1, 0}});
      // extreme vertices
      table_rows.push_back('{load_req(0, MINC, MINC, MINC), 0, none});
      table_rows.push_back('{load_req(1, MAXC, MINC, MINC), 0, none});
      table_rows.push_back('{load_req(2, MINC, MAXC, MINC), 0, none});
      table_rows.push_back('{load_req(3, MINC, MINC, MAXC), 0, none});
      table_rows.push_back('{query_req(0, 0, 0), 0, none});
      table_rows.push_back('{query_req(MAXC, MAXC, MAXC), 0, none});
      table_rows.push_back('{query_req(MINC, MINC, MINC), 0, none});
      table_rows.push_back('{query_req(-1, -1, -1), 0, none});
      foreach (table_rows[i])
         send_request(table_rows[i].req, table_rows[i].known, table_rows[i].coords);

      // sender holds off until the pipeline is empty
      drain();

      n = 0;
      while (n < 1030) begin
         if (n > 900) no_gaps = 1'b1;
         if ($urandom_range(0, 9) == 0) begin
            // new element: all four vertices
            for (int s = 0; s < 4; s++) begin
               if ($urandom_range(0, 7) == 0)
                  r = load_req(s, rand_coord(), rand_coord(), rand_coord());
               else
                  r = load_req(s, coord_type'(int'($urandom_range(0, 6 * ONE)) - 3 * ONE),
                               coord_type'(int'($urandom_range(0, 6 * ONE)) - 3 * ONE),
                               coord_type'(int'($urandom_range(0, 6 * ONE)) - 3 * ONE));
               send_request(r, 1'b0, none);
               n++;
            end
         end else if ($urandom_range(0, 15) == 0) begin
            // single vertex rewrite, all slots already loaded
            send_request(load_req($urandom_range(0, 3), rand_coord(), rand_coord(),
                                  rand_coord()), 1'b0, none);
            n++;
         end else begin
            send_request(query_req(rand_coord(), rand_coord(), rand_coord()), 1'b0, none);
            n++;
         end
      end
      drain();

      if (errors == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule
